FILE: design/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 7;
    localparam int VAL_W = 32;
    localparam int CMD_W = 3;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic            load_in;
        logic            idx_init;
        logic            rd;
        logic            wr_shift;
        logic            wr_final;
        logic            srch_step;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            set_found;
        logic            load_out;
    } ple_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_bad;
        logic             full;
        logic             shift_more;
        logic             srch_more;
        logic             match;
        logic             out_busy;
    } ple_stat_t;

endpackage

FILE: design/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_cmd_t  ctl
);
    import ple_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECODE    = 7'b0000010,
        S_SHIFT_CHK = 7'b0000100,
        S_SHIFT_WR  = 7'b0001000,
        S_SRCH_CHK  = 7'b0010000,
        S_SRCH_CMP  = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.status = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                if (stat.cmd == CMD_INSERT) begin
                    if (stat.pos_bad) begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_RANGE;
                    end else if (stat.full) begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_FULL;
                    end else begin
                        ctl.idx_init = 1'b1;
                        state_next   = S_SHIFT_CHK;
                    end
                end else if (stat.cmd inside {CMD_UPDATE, CMD_DELETE}) begin
                    if (stat.pos_bad) begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_RANGE;
                    end else if (stat.cmd == CMD_UPDATE) begin
                        ctl.wr_final = 1'b1;
                    end else begin
                        ctl.idx_init = 1'b1;
                        state_next   = S_SHIFT_CHK;
                    end
                end else if (stat.cmd == CMD_SEARCH) begin
                    ctl.idx_init = 1'b1;
                    state_next   = S_SRCH_CHK;
                end
            end
            S_SHIFT_CHK: begin
                if (stat.shift_more) begin
                    ctl.rd     = 1'b1;
                    state_next = S_SHIFT_WR;
                end else begin
                    ctl.wr_final = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                ctl.wr_shift = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_SRCH_CHK: begin
                if (stat.srch_more) begin
                    ctl.rd     = 1'b1;
                    state_next = S_SRCH_CMP;
                end else begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_MISSING;
                    state_next     = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                if (stat.match) begin
                    ctl.set_found = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    ctl.srch_step = 1'b1;
                    state_next    = S_SRCH_CHK;
                end
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ple_datapath.sv
`timescale 1ns / 1ps

module ple_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [47:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    input  ple_pkg::ple_cmd_t  ctl,
    output ple_pkg::ple_stat_t stat
);
    import ple_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    logic [CMD_W-1:0] cmd_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [VAL_W-1:0] rd_data_reg;
    logic [ST_W-1:0]  status_reg;
    logic [CNT_W-1:0] found_reg;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;

    logic             is_ins;
    logic             is_del;
    logic [CNT_W-1:0] rd_addr;
    logic [CNT_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             wr_en;

    assign is_ins = (cmd_reg == CMD_INSERT);
    assign is_del = (cmd_reg == CMD_DELETE);

    // Insert copies each entry one place up, from the tail down; delete copies
    // each entry one place down, from the hole up.
    always_comb begin
        if (is_ins) begin
            rd_addr = idx_reg - CNT_W'(1);
        end else if (is_del) begin
            rd_addr = idx_reg + CNT_W'(1);
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (ctl.wr_shift) begin
            wr_en = 1'b1;
        end else if (ctl.wr_final && !is_del) begin
            wr_en   = 1'b1;
            wr_data = val_reg;
            wr_addr = is_ins ? pos_reg : (pos_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (ctl.rd) begin
            rd_data_reg <= mem[rd_addr[IDX_W-1:0]];
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (ctl.idx_init) begin
            if (is_ins) begin
                idx_next = fill_reg;
            end else if (is_del) begin
                idx_next = pos_reg - CNT_W'(1);
            end else begin
                idx_next = '0;
            end
        end else if (ctl.wr_shift) begin
            idx_next = is_ins ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));
        end else if (ctl.srch_step) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (ctl.wr_final && is_ins) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (ctl.wr_final && is_del) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            pos_reg <= s_tdata[CMD_W +: CNT_W];
            val_reg <= s_tdata[CMD_W+CNT_W +: VAL_W];
        end
        idx_reg <= idx_next;
        if (ctl.load_in) begin
            status_reg <= ST_OK;
            found_reg  <= '0;
        end else begin
            if (ctl.set_status) begin
                status_reg <= ctl.status;
            end
            if (ctl.set_found) begin
                found_reg <= idx_reg + CNT_W'(1);
            end
        end
        if (ctl.load_out) begin
            m_tdata_reg <= {fill_reg, found_reg, status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (ctl.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        stat.cmd        = cmd_reg;
        stat.pos_bad    = is_ins ? (pos_reg > fill_reg)
                                 : ((pos_reg == '0) || (pos_reg > fill_reg));
        stat.full       = (fill_reg == CNT_W'(DEPTH));
        stat.shift_more = is_ins ? (idx_reg > pos_reg)
                                 : ((idx_reg + CNT_W'(1)) < fill_reg);
        stat.srch_more  = (idx_reg < fill_reg);
        stat.match      = (rd_data_reg == val_reg);
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

endmodule

FILE: design/positional_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to 64 signed 32-bit values with an entry count.
// Input beats on s_t* carry one command each (insert after, update, delete,
// search, count); every command yields exactly one result beat on m_t*
// with a status, the found position and the entry count after the command.
// The list lives in a single-port-write, single-read memory, so an insert
// or delete moves one entry at a time, with a read state and a write state
// per entry, and a search reads and compares one entry at a time. Count,
// update and any rejected command go from decode straight to the result;
// insert and delete shift the entries between the position and the tail;
// a search stops at the first match. One command is worked on at a time;
// s_tready is high only while the engine is idle, but a finished result
// held in the output register does not block the next command. If the
// receiver stalls with a result still waiting, the next result is held
// until that beat is taken. A synchronous low aresetn empties the list and
// drops m_tvalid; the entry memory itself is not cleared and needs no sweep.
module positional_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // cmd[2:0], position[9:3], value[41:10], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // status[1:0], found_position[8:2], entry_count[15:9]
);
    import ple_pkg::*;

    ple_cmd_t  ctl;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ple_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .stat     (stat)
    );

endmodule

FILE: tb/sv/positional_list_engine_test.sv
`timescale 1ns / 1ps

module positional_list_engine_test;
    import ple_pkg::*;

    localparam int CHECK = 0;   // list state advanced on accepted beats
    localparam int PLAN  = 1;   // list state advanced as commands are queued
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 200;

    // Codes the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [6:0]       position;
        logic [CMD_W-1:0] cmd;
    } command_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic [6:0]       found_position;
        logic [ST_W-1:0]  status;
    } list_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [VAL_W-1:0] list_cells [2][DEPTH];
    int               list_fill [2] = '{0, 0};

    command_t    pending_cmds [$];
    list_reply_t awaited_replies [$];
    logic        in_fire = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          queued_total = 0;
    int          accepted_total = 0;
    int          replies_checked = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          cmd_hits [8] = '{default: 0};
    int          status_hits [4] = '{default: 0};

    positional_list_engine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Applies one command to one copy of the list and returns the reply.
    function automatic list_reply_t apply_command(input int side, input command_t c);
        list_reply_t r;
        int f;
        int p;
        r.status = ST_OK;
        r.found_position = '0;
        f = list_fill[side];
        p = c.position;
        case (c.cmd)
            CMD_INSERT: begin
                if (p > f) begin
                    r.status = ST_RANGE;
                end else if (f >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = f; i > p; i--)
                        list_cells[side][i] = list_cells[side][i-1];
                    list_cells[side][p] = c.value;
                    f++;
                end
            end
            CMD_UPDATE: begin
                if (p == 0 || p > f)
                    r.status = ST_RANGE;
                else
                    list_cells[side][p-1] = c.value;
            end
            CMD_DELETE: begin
                if (p == 0 || p > f) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = p - 1; i + 1 < f; i++)
                        list_cells[side][i] = list_cells[side][i+1];
                    f--;
                end
            end
            CMD_SEARCH: begin
                r.status = ST_MISSING;
                for (int i = 0; i < f; i++) begin
                    if (r.status == ST_MISSING && list_cells[side][i] == c.value) begin
                        r.found_position = 7'(i + 1);
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        list_fill[side] = f;
        r.entry_count = 7'(f);
        return r;
    endfunction

    task automatic queue_command(input logic [CMD_W-1:0] cmd, input int pos,
                                 input logic [VAL_W-1:0] val);
        command_t c;
        c.cmd = cmd;
        c.position = 7'(pos);
        c.value = val;
        void'(apply_command(PLAN, c));
        pending_cmds.push_back(c);
        queued_total++;
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || awaited_replies.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] pool [8];
        pool = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0,
                 32'h1, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h00010000};
        if ($urandom_range(99) < 40)
            return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Runs of growth, shrinkage and mixed traffic, so the list fills up,
    // overflows and empties again several times.
    task automatic plan_random(input int n);
        int mode;
        int mode_left;
        int f;
        int ins_pct;
        int del_pct;
        int roll;
        int pos;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        mode = 0;
        mode_left = 0;
        for (int k = 0; k < n; k++) begin
            if (mode_left == 0) begin
                mode = $urandom_range(2);
                mode_left = (mode == 0) ? $urandom_range(160, 100) : $urandom_range(60, 20);
            end
            mode_left--;
            ins_pct = (mode == 0) ? 70 : (mode == 1) ? 15 : 35;
            del_pct = (mode == 0) ? 8 : (mode == 1) ? 55 : 25;
            f = list_fill[PLAN];
            roll = $urandom_range(99);
            if (roll < 3) begin
                cmd = 3'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
            end else if (roll < 8) begin
                cmd = CMD_COUNT;
            end else begin
                roll = $urandom_range(99);
                if (roll < ins_pct)
                    cmd = CMD_INSERT;
                else if (roll < ins_pct + del_pct)
                    cmd = CMD_DELETE;
                else if (roll[0])
                    cmd = CMD_UPDATE;
                else
                    cmd = CMD_SEARCH;
            end
            if ($urandom_range(99) < 8 || cmd == CMD_SEARCH || cmd >= CMD_COUNT)
                pos = $urandom_range(127);
            else if (cmd == CMD_INSERT)
                pos = $urandom_range(f, 0);
            else if (f == 0)
                pos = $urandom_range(127);
            else
                pos = $urandom_range(f, 1);
            if (cmd == CMD_SEARCH && f > 0 && $urandom_range(99) < 60)
                val = list_cells[PLAN][$urandom_range(f - 1)];
            else
                val = pick_value();
            queue_command(cmd, pos, val);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (!s_tvalid || in_fire) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= {6'd0, pending_cmds.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        command_t    c;
        list_reply_t want;
        list_reply_t got;
        cycle_count++;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c = command_t'(s_tdata[41:0]);
                want = apply_command(CHECK, c);
                awaited_replies.push_back(want);
                accepted_total++;
                cmd_hits[c.cmd]++;
            end
            if (m_tvalid && m_tready) begin
                got = list_reply_t'(m_tdata);
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with none expected, actual %h", $time, m_tdata);
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("found_position", want.found_position, got.found_position);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    status_hits[want.status]++;
                    replies_checked++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     awaited_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty list corner cases, then a short list built at both ends.
        queue_command(CMD_COUNT, 0, 32'h0);
        queue_command(CMD_SEARCH, 0, 32'h0);
        queue_command(CMD_UPDATE, 1, 32'h1234);
        queue_command(CMD_DELETE, 0, 32'h0);
        queue_command(CMD_INSERT, 1, 32'h1);
        queue_command(CMD_INSERT, 0, 32'h7fffffff);
        queue_command(CMD_INSERT, 1, 32'h80000000);
        queue_command(CMD_INSERT, 0, 32'hffffffff);
        queue_command(CMD_SEARCH, 0, 32'hffffffff);
        queue_command(CMD_SEARCH, 0, 32'h80000000);
        queue_command(CMD_SEARCH, 0, 32'h7ffffffe);
        queue_command(CMD_UPDATE, 0, 32'h0);
        queue_command(CMD_UPDATE, 3, 32'h0);
        queue_command(CMD_UPDATE, 4, 32'h0);
        queue_command(CMD_INSERT, 127, 32'h0);
        queue_command(CMD_DELETE, 1, 32'h0);
        queue_command(CMD_DELETE, 2, 32'h0);
        queue_command(CMD_SEARCH, 0, 32'h0);
        queue_command(CMD_DELETE, 127, 32'h0);
        queue_command(CMD_SPARE_A, 127, 32'hffffffff);
        queue_command(CMD_SPARE_B, 64, 32'h0);
        queue_command(CMD_SPARE_C, 1, 32'h55555555);
        queue_command(CMD_COUNT, 127, 32'haaaaaaaa);
        wait_drained();

        send_idle_pct = 12;
        recv_idle_pct = 52;
        plan_random(520);
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 12;
        plan_random(520);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        plan_random(520);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Commands: insert %0d, update %0d, delete %0d, search %0d, count %0d, spare %0d",
                 cmd_hits[CMD_INSERT], cmd_hits[CMD_UPDATE], cmd_hits[CMD_DELETE],
                 cmd_hits[CMD_SEARCH], cmd_hits[CMD_COUNT],
                 cmd_hits[CMD_SPARE_A] + cmd_hits[CMD_SPARE_B] + cmd_hits[CMD_SPARE_C]);
        $display("%0d results checked: ok %0d, range %0d, full %0d, not found %0d; %0d mismatches",
                 replies_checked, status_hits[ST_OK], status_hits[ST_RANGE],
                 status_hits[ST_FULL], status_hits[ST_MISSING], mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
